// File: hdl/pnc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prefixed number converter package
// Shared widths, character codes, word state type and digit decoding.
// ----------------------------------------------------------------------------
package pnc_pkg;

	localparam int CH_W    = 8;
	localparam int VALUE_W = 16;
	localparam int RADIX_W = 6;
	localparam int POS_W   = 3;
	localparam int DIGIT_W = 8;

	localparam logic [POS_W-1:0]   POS_MAX     = 3'd7;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_BIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX   = 6'd16;

	localparam logic [CH_W-1:0] CH_QUOTE   = 8'h27;
	localparam logic [CH_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [CH_W-1:0] CH_HASH    = 8'h23;
	localparam logic [CH_W-1:0] CH_DOLLAR  = 8'h24;
	localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
	localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7a;
	localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5a;
	localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE    = 8'h39;

	localparam logic [DIGIT_W-1:0] DIGIT_NONE   = 8'hff;
	localparam logic [DIGIT_W-1:0] DIGIT_LETTER = 8'd10;

	typedef enum logic [2:0] {
		KIND_PLAIN  = 3'b001,
		KIND_CHAR   = 3'b010,
		KIND_PREFIX = 3'b100
	} word_kind_t;

	typedef struct packed {
		logic [POS_W-1:0]   position;
		word_kind_t         kind;
		logic [RADIX_W-1:0] radix;
		logic               neg;
		logic               err;
		logic               seen;
	} word_state_t;

	localparam word_state_t WORD_RESET = '{
		position: '0,
		kind:     KIND_PLAIN,
		radix:    RADIX_RESET,
		neg:      1'b0,
		err:      1'b0,
		seen:     1'b0
	};

	function automatic logic [DIGIT_W-1:0] digit_value(input logic [CH_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = DIGIT_NONE;
		if (c inside {[CH_ZERO:CH_NINE]}) begin
			d = c - CH_ZERO;
		end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
			d = DIGIT_LETTER + (c - CH_LOWER_A);
		end else if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
			d = DIGIT_LETTER + (c - CH_UPPER_A);
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// File: hdl/pnc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Character input channel
// Valid/ready channel carrying one character and its end-of-word flag.
// ----------------------------------------------------------------------------
interface pnc_in_if;
	logic                      valid;
	logic                      ready;
	logic [pnc_pkg::CH_W-1:0]  ch;
	logic                      last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface
`default_nettype wire

// File: hdl/pnc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying the converted value and its valid flag.
// ----------------------------------------------------------------------------
interface pnc_out_if;
	logic                         valid;
	logic                         ready;
	logic [pnc_pkg::VALUE_W-1:0]  value;
	logic                         ok;

	modport source (output valid, output value, output ok, input ready);
	modport sink (input valid, input value, input ok, output ready);
endinterface
`default_nettype wire

// File: hdl/pnc_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the default radix register write data.
// ----------------------------------------------------------------------------
interface pnc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [pnc_pkg::RADIX_W-1:0]  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/prefixed_number_converter_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prefixed number converter
// Converts a stream of characters, one word at a time, to a signed number.
// ----------------------------------------------------------------------------
// Takes one character per cycle on din while dout is free, with last set on
// the final character of a word; each word gives one result on dout, loaded
// from the input register into the result register once dout is free. A
// leading %, # or $ selects radix 2, 10 or 16, otherwise the cfg register
// (reset 10) gives the radix; a quoted character 'x' yields its code. This
// rate is set by the single accumulator multiply-add between the input and
// result registers. ok is low and value zero for an invalid word. Write cfg
// only while no word is in flight.
module prefixed_number_converter_top #(
	parameter int CELL_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	pnc_in_if.sink       din,
	pnc_out_if.source    dout,
	pnc_cfg_if.sink      cfg
);

	logic                            valid_s1;
	logic [pnc_pkg::CH_W-1:0]        ch_s1;
	logic                            last_s1;
	pnc_pkg::word_state_t            st_q;
	logic [CELL_BITS-1:0]            acc_q;
	logic [pnc_pkg::RADIX_W-1:0]     base_q;
	logic                            out_valid_q;
	logic [pnc_pkg::VALUE_W-1:0]     value_q;
	logic                            ok_q;

	pnc_pkg::word_state_t            st_nxt;
	logic [CELL_BITS-1:0]            acc_nxt;
	logic [pnc_pkg::VALUE_W-1:0]     res_value;
	logic                            res_ok;
	logic                            out_free;
	logic                            adv;
	logic                            load_out;

	assign out_free = !out_valid_q || dout.ready;
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign load_out = adv && last_s1;
	assign din.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	assign dout.valid = out_valid_q;
	assign dout.value = value_q;
	assign dout.ok    = ok_q;

	pnc_step #(
		.CELL_BITS (CELL_BITS)
	) u_step (
		.st      (st_q),
		.acc     (acc_q),
		.ch      (ch_s1),
		.last    (last_s1),
		.base    (base_q),
		.st_nxt  (st_nxt),
		.acc_nxt (acc_nxt),
		.value   (res_value),
		.ok      (res_ok)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			st_q        <= pnc_pkg::WORD_RESET;
			acc_q       <= '0;
			base_q      <= pnc_pkg::RADIX_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (din.ready) begin
				valid_s1 <= din.valid;
			end
			if (adv) begin
				st_q  <= st_nxt;
				acc_q <= acc_nxt;
			end
			if (cfg.valid && cfg.ready) begin
				base_q <= cfg.data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			ch_s1   <= din.ch;
			last_s1 <= din.last;
		end
		if (load_out) begin
			value_q <= res_value;
			ok_q    <= res_ok;
		end
	end

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (st_q.position == '0 && acc_q == '0 && !st_q.neg))
		else $error("word state not cleared after last character");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !ok_q) |-> (value_q == '0))
		else $error("invalid word carries a non-zero value");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |-> !din.ready)
		else $error("input taken while stage one is stalled");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(load_out))
		else $error("result appeared without a last character");
`endif

endmodule
`default_nettype wire

// File: hdl/pnc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Prefixed number converter step
// Next word state, accumulator and result for one character.
// ----------------------------------------------------------------------------
module pnc_step #(
	parameter int CELL_BITS = 16
) (
	input  pnc_pkg::word_state_t          st,
	input  logic [CELL_BITS-1:0]          acc,
	input  logic [pnc_pkg::CH_W-1:0]      ch,
	input  logic                          last,
	input  logic [pnc_pkg::RADIX_W-1:0]   base,
	output pnc_pkg::word_state_t          st_nxt,
	output logic [CELL_BITS-1:0]          acc_nxt,
	output logic [pnc_pkg::VALUE_W-1:0]   value,
	output logic                          ok
);

	localparam int PW = CELL_BITS + pnc_pkg::RADIX_W;

	pnc_pkg::word_state_t            ns;
	logic                            first;
	logic                            is_quote;
	logic                            is_prefix;
	logic                            numeric;
	logic                            sign_slot;
	logic [pnc_pkg::RADIX_W-1:0]     prefix_radix;
	logic [pnc_pkg::DIGIT_W-1:0]     d;
	logic [PW-1:0]                   prod;
	logic [CELL_BITS-1:0]            mac;
	logic [CELL_BITS-1:0]            acc_w;
	logic [CELL_BITS-1:0]            acc_neg;

	always_comb begin
		ns        = st;
		acc_w     = acc;
		first     = (st.position == '0);
		is_quote  = (ch == pnc_pkg::CH_QUOTE);
		is_prefix = (ch == pnc_pkg::CH_PERCENT) || (ch == pnc_pkg::CH_HASH) ||
			(ch == pnc_pkg::CH_DOLLAR);
		case (ch)
			pnc_pkg::CH_PERCENT: prefix_radix = pnc_pkg::RADIX_BIN;
			pnc_pkg::CH_HASH:    prefix_radix = pnc_pkg::RADIX_DEC;
			default:             prefix_radix = pnc_pkg::RADIX_HEX;
		endcase

		if (first) begin
			ns.radix = is_prefix ? prefix_radix : base;
			if (is_quote) begin
				ns.kind = pnc_pkg::KIND_CHAR;
			end else if (is_prefix) begin
				ns.kind = pnc_pkg::KIND_PREFIX;
			end else begin
				ns.kind = pnc_pkg::KIND_PLAIN;
			end
		end

		numeric   = first ? (!is_quote && !is_prefix) : (st.kind != pnc_pkg::KIND_CHAR);
		sign_slot = first ||
			(st.kind == pnc_pkg::KIND_PREFIX && st.position == pnc_pkg::POS_W'(1));
		d    = pnc_pkg::digit_value(ch);
		prod = PW'(acc) * PW'(ns.radix);
		mac  = CELL_BITS'(prod + PW'(d));

		if (numeric) begin
			if (ch == pnc_pkg::CH_MINUS && sign_slot && !st.neg && !st.seen) begin
				ns.neg = 1'b1;
			end else if (d >= pnc_pkg::DIGIT_W'(ns.radix)) begin
				ns.err = 1'b1;
			end else begin
				acc_w   = mac;
				ns.seen = 1'b1;
			end
		end else if (!first) begin
			if (st.position == pnc_pkg::POS_W'(1)) begin
				acc_w = CELL_BITS'(ch);
			end else if (st.position == pnc_pkg::POS_W'(2)) begin
				if (!is_quote) begin
					ns.err = 1'b1;
				end
			end else begin
				ns.err = 1'b1;
			end
		end

		if (ns.kind == pnc_pkg::KIND_CHAR) begin
			ok = !ns.err && (st.position == pnc_pkg::POS_W'(2));
		end else begin
			ok = !ns.err && ns.seen;
		end

		acc_neg = '0 - acc_w;
		if (!ok) begin
			value = '0;
		end else if (ns.neg) begin
			value = pnc_pkg::VALUE_W'(acc_neg);
		end else begin
			value = pnc_pkg::VALUE_W'(acc_w);
		end

		if (last) begin
			st_nxt  = pnc_pkg::WORD_RESET;
			acc_nxt = '0;
		end else begin
			st_nxt          = ns;
			st_nxt.position = (st.position == pnc_pkg::POS_MAX) ? st.position :
				st.position + pnc_pkg::POS_W'(1);
			acc_nxt         = acc_w;
		end
	end

endmodule
`default_nettype wire
